// ----- hdl/bfws_pkg.sv -----
`default_nettype none
package bfws_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MAX_RADIUS = 15;

    localparam int SPAN_MAX   = 2 * MAX_RADIUS + 1;

    // fixed field widths
    localparam int PIX_W      = 8;
    localparam int DIM_W      = 11;
    localparam int CFG_RAD_W  = 4;
    localparam int HS_W       = 13;
    localparam int CS_W       = 18;
    localparam int POS_W      = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int OUT_DATA_W = 40;

    // derived widths
    localparam int VC_W       = $clog2(MAX_WIDTH + MAX_RADIUS + 1);
    localparam int VR_W       = $clog2(MAX_HEIGHT + MAX_RADIUS + 1);
    localparam int RAD_W      = $clog2(MAX_RADIUS + 1);
    localparam int SLOT_W     = $clog2(SPAN_MAX + 1);
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_DEPTH  = SPAN_MAX * MAX_WIDTH;
    localparam int ROW_ADDR_W = $clog2(ROW_DEPTH);

    localparam int OUT_DEPTH  = 3;
    localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RADIUS = 2'd2;

    typedef struct packed {
        logic                  valid;
        logic                  upd;
        logic                  emit;
        logic                  first_row;
        logic                  old_valid;
        logic [ROW_ADDR_W-1:0] row_addr;
        logic [COL_W-1:0]      col;
        logic [HS_W-1:0]       hsum;
        logic [POS_W-1:0]      out_row;
        logic [POS_W-1:0]      out_col;
        logic                  frame_last;
    } bfws_req_t;

    typedef struct packed {
        logic             frame_last;
        logic [POS_W-1:0] out_col;
        logic [POS_W-1:0] out_row;
        logic [CS_W-1:0]  box_sum;
    } bfws_res_t;

endpackage
`default_nettype wire

// ----- hdl/box_filter_window_sum_top.sv -----
`default_nettype none
// channel  direction  handshake          payload
// s_*      in         s_tvalid/s_tready  s_tdata: pixel
// m_*      out        m_tvalid/m_tready  m_tdata: box_sum, out_row, out_col; m_tlast: frame_last
// cfg_*    in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// one pixel per clock while s_tready is high; an item is read in its accept cycle and its column
// sum is updated in the next cycle from the two registered-read stores
// results wait in a three-entry output queue, so s_tready only drops when
// m_tready has been low long enough to fill it
// rst_n clears counters and queue and sets config to 1024 x 1024, radius 1; the stores need no clearing
// a config write restarts the frame at virtual row 0, column 0
module box_filter_window_sum_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [bfws_pkg::PIX_W-1:0]    s_tdata,   // [7:0] pixel
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [bfws_pkg::OUT_DATA_W-1:0]    m_tdata,   // [17:0] box_sum, [27:18] out_row, [37:28] out_col
    output logic                               m_tlast,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [bfws_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bfws_pkg::DIM_W-1:0]    cfg_data
);
    import bfws_pkg::*;

    logic [DIM_W-1:0]     cfg_width_reg;
    logic [DIM_W-1:0]     cfg_height_reg;
    logic [CFG_RAD_W-1:0] cfg_radius_reg;

    logic [VC_W-1:0]   vc_reg;
    logic [VR_W-1:0]   vr_reg;
    logic [SLOT_W-1:0] hslot_reg;
    logic [SLOT_W-1:0] rslot_reg;
    logic [HS_W-1:0]   hsum_reg;
    logic [PIX_W-1:0]  hist_reg [SPAN_MAX];

    logic [VC_W-1:0]   w_eff;
    logic [VR_W-1:0]   h_eff;
    logic [RAD_W-1:0]  r_eff;
    logic [SLOT_W-1:0] span_m1;
    logic [VC_W-1:0]   span_c;
    logic [VR_W-1:0]   span_r;
    logic              row_end;
    logic              frame_end;
    logic              accept;
    logic              cfg_hit;
    logic [PIX_W-1:0]  pix;
    logic [PIX_W-1:0]  old_pix;
    logic [HS_W-1:0]   hsum_next;
    logic [VC_W-1:0]   col_full;
    logic [VR_W-1:0]   row_full;
    bfws_req_t         req;

    logic              s1_pending;
    logic              res_push;
    bfws_res_t         res;
    logic              q_valid;
    bfws_res_t         q_head;
    logic [OUT_CNT_W-1:0] q_count;

    always_comb
    begin
        if (cfg_width_reg == '0)
            w_eff = VC_W'(1);
        else if (cfg_width_reg > DIM_W'(MAX_WIDTH))
            w_eff = VC_W'(MAX_WIDTH);
        else
            w_eff = VC_W'(cfg_width_reg);

        if (cfg_height_reg == '0)
            h_eff = VR_W'(1);
        else if (cfg_height_reg > DIM_W'(MAX_HEIGHT))
            h_eff = VR_W'(MAX_HEIGHT);
        else
            h_eff = VR_W'(cfg_height_reg);

        if (cfg_radius_reg > CFG_RAD_W'(MAX_RADIUS))
            r_eff = RAD_W'(MAX_RADIUS);
        else
            r_eff = RAD_W'(cfg_radius_reg);
    end

    assign span_m1   = SLOT_W'({r_eff, 1'b0});
    assign span_c    = VC_W'(span_m1) + 1'b1;
    assign span_r    = VR_W'(span_m1) + 1'b1;
    assign row_end   = (vc_reg == w_eff + VC_W'(r_eff) - 1'b1);
    assign frame_end = (vr_reg == h_eff + VR_W'(r_eff) - 1'b1);

    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid && ((cfg_index == REG_FRAME_WIDTH) ||
                       (cfg_index == REG_FRAME_HEIGHT) || (cfg_index == REG_WINDOW_RADIUS));

    // room for the item in stage one plus this one, counting queued results
    assign s_tready = (OUT_CNT_W'(q_count) + OUT_CNT_W'(s1_pending)) < OUT_CNT_W'(OUT_DEPTH);
    assign accept   = s_tvalid && s_tready;

    // horizontal running sum over the last 2r+1 columns
    always_comb
    begin
        pix       = ((vr_reg < h_eff) && (vc_reg < w_eff)) ? s_tdata : '0;
        old_pix   = (vc_reg >= span_c) ? hist_reg[hslot_reg] : '0;
        hsum_next = ((vc_reg == '0) ? '0 : hsum_reg) + HS_W'(pix) - HS_W'(old_pix);
        col_full  = vc_reg - VC_W'(r_eff);
        row_full  = vr_reg - VR_W'(r_eff);
    end

    always_comb
    begin
        req.valid      = accept;
        req.upd        = (vc_reg >= VC_W'(r_eff));
        req.emit       = req.upd && (vr_reg >= VR_W'(r_eff));
        req.first_row  = (vr_reg == '0);
        req.old_valid  = (vr_reg >= span_r);
        req.col        = col_full[COL_W-1:0];
        req.row_addr   = ROW_ADDR_W'(rslot_reg) * ROW_ADDR_W'(MAX_WIDTH)
                         + ROW_ADDR_W'(col_full[COL_W-1:0]);
        req.hsum       = hsum_next;
        req.out_row    = row_full[POS_W-1:0];
        req.out_col    = col_full[POS_W-1:0];
        req.frame_last = row_end && frame_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_width_reg  <= DIM_W'(1024);
            cfg_height_reg <= DIM_W'(1024);
            cfg_radius_reg <= CFG_RAD_W'(1);
            vc_reg         <= '0;
            vr_reg         <= '0;
            hslot_reg      <= '0;
            rslot_reg      <= '0;
            hsum_reg       <= '0;
        end
        else if (cfg_hit)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:   cfg_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT:  cfg_height_reg <= cfg_data;
                REG_WINDOW_RADIUS: cfg_radius_reg <= cfg_data[CFG_RAD_W-1:0];
                default:           cfg_radius_reg <= cfg_radius_reg;
            endcase
            vc_reg    <= '0;
            vr_reg    <= '0;
            hslot_reg <= '0;
            rslot_reg <= '0;
        end
        else if (accept)
        begin
            hsum_reg <= hsum_next;
            if (row_end)
            begin
                vc_reg    <= '0;
                hslot_reg <= '0;
                if (frame_end)
                begin
                    vr_reg    <= '0;
                    rslot_reg <= '0;
                end
                else
                begin
                    vr_reg    <= vr_reg + 1'b1;
                    rslot_reg <= (rslot_reg == span_m1) ? '0 : rslot_reg + 1'b1;
                end
            end
            else
            begin
                vc_reg    <= vc_reg + 1'b1;
                hslot_reg <= (hslot_reg == span_m1) ? '0 : hslot_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            hist_reg[hslot_reg[$clog2(SPAN_MAX)-1:0]] <= pix;
    end

    bfws_colacc u_colacc (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .pending (s1_pending),
        .push    (res_push),
        .res     (res)
    );

    bfws_out_fifo u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res_push),
        .push_data  (res),
        .pop        (m_tready),
        .head_valid (q_valid),
        .head_data  (q_head),
        .count      (q_count)
    );

    assign m_tvalid = q_valid;
    assign m_tdata  = {{(OUT_DATA_W - CS_W - 2 * POS_W){1'b0}},
                       q_head.out_col, q_head.out_row, q_head.box_sum};
    assign m_tlast  = q_head.frame_last;

endmodule
`default_nettype wire

// ----- hdl/bfws_colacc.sv -----
`default_nettype none
module bfws_colacc (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bfws_pkg::bfws_req_t req,
    output logic                    pending,
    output logic                    push,
    output bfws_pkg::bfws_res_t     res
);
    import bfws_pkg::*;

    logic [HS_W-1:0] row_mem [ROW_DEPTH];
    logic [CS_W-1:0] col_mem [MAX_WIDTH];

    logic            s1_valid_reg;
    bfws_req_t       s1_reg;
    logic [HS_W-1:0] row_rd_reg;
    logic [CS_W-1:0] col_rd_reg;
    logic            row_fwd_reg;
    logic            col_fwd_reg;
    logic [HS_W-1:0] row_fwd_data_reg;
    logic [CS_W-1:0] col_fwd_data_reg;

    logic            wr_en;
    logic [HS_W-1:0] old_row;
    logic [CS_W-1:0] col_prev;
    logic [CS_W-1:0] col_new;

    assign wr_en = s1_valid_reg && s1_reg.upd;

    always_comb
    begin
        if (!s1_reg.old_valid)
            old_row = '0;
        else if (row_fwd_reg)
            old_row = row_fwd_data_reg;
        else
            old_row = row_rd_reg;

        if (s1_reg.first_row)
            col_prev = '0;
        else if (col_fwd_reg)
            col_prev = col_fwd_data_reg;
        else
            col_prev = col_rd_reg;

        col_new = col_prev + CS_W'(s1_reg.hsum) - CS_W'(old_row);
    end

    // row sum line store, read old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (wr_en)
            row_mem[s1_reg.row_addr] <= s1_reg.hsum;
        row_rd_reg <= row_mem[req.row_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            col_mem[s1_reg.col] <= col_new;
        col_rd_reg <= col_mem[req.col];
    end

    // the entry being written now is stale in the read data of the next item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            row_fwd_reg  <= 1'b0;
            col_fwd_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= req.valid;
            row_fwd_reg  <= wr_en && (s1_reg.row_addr == req.row_addr);
            col_fwd_reg  <= wr_en && (s1_reg.col == req.col);
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg           <= req;
        row_fwd_data_reg <= s1_reg.hsum;
        col_fwd_data_reg <= col_new;
    end

    assign pending        = s1_valid_reg && s1_reg.emit;
    assign push           = pending;
    assign res.box_sum    = col_new;
    assign res.out_row    = s1_reg.out_row;
    assign res.out_col    = s1_reg.out_col;
    assign res.frame_last = s1_reg.frame_last;

endmodule
`default_nettype wire

// ----- hdl/bfws_out_fifo.sv -----
`default_nettype none
module bfws_out_fifo (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire bfws_pkg::bfws_res_t push_data,
    input  wire logic                pop,
    output logic                     head_valid,
    output bfws_pkg::bfws_res_t      head_data,
    output logic [bfws_pkg::OUT_CNT_W-1:0] count
);
    import bfws_pkg::*;

    bfws_res_t              slot_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [OUT_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [OUT_CNT_W-1:0]   count_reg, count_next;
    logic                   do_pop;

    assign do_pop     = pop && (count_reg != '0);
    assign head_valid = (count_reg != '0);
    assign head_data  = slot_reg[rd_ptr_reg];
    assign count      = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            count_next  = count_next + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_next  = count_next - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule
`default_nettype wire
